// File: rtl/scc_pkg.sv
package scc_pkg;

   // payload widths of the request and response transfers
   localparam int FUNC_W  = 1;
   localparam int NODE_W  = 6;
   localparam int COUNT_W = 7;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ADD_ROAD = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_CHECK    = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_SRC,
      ST_WR_SRC,
      ST_RD_DST,
      ST_WR_DST,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;          // request channel ready
      logic road_read;     // read the row that a road edits
      logic road_write;    // write the edited row back
      logic road_rev;      // work on the reverse edge of the road
      logic scan_read;     // read the next row of a sweep
      logic sweep_restart; // start another sweep over the rows
      logic finish;        // publish the answer and clear the graph
   } scc_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_valid;     // a request is offered
      logic req_check;     // the offered request is a check
      logic two_way;       // the current road also adds the reverse edge
      logic trivial;       // node count settles the answer without a walk
      logic last_row;      // the sweep reads its last row this cycle
      logic changed;       // a set grew during the current sweep
      logic out_free;      // the response register can take an answer
   } scc_status_type;

endpackage

// File: rtl/scc_req_if.sv
interface scc_req_if;
   import scc_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [NODE_W-1:0]  source_node;
   logic [NODE_W-1:0]  dest_node;
   logic               two_way;
   logic [COUNT_W-1:0] node_count;

   modport source (
      output valid, func, source_node, dest_node, two_way, node_count,
      input  ready
   );

   modport sink (
      input  valid, func, source_node, dest_node, two_way, node_count,
      output ready
   );

endinterface

// File: rtl/scc_rsp_if.sv
interface scc_rsp_if;

   logic valid;
   logic ready;
   logic connected;

   modport source (
      output valid, connected,
      input  ready
   );

   modport sink (
      input  valid, connected,
      output ready
   );

endinterface

// File: rtl/scc_ctrl.sv
module scc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  scc_pkg::scc_status_type status,
   output scc_pkg::scc_cmd_type    cmd
);
   import scc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (status.req_valid) begin
               state_in = status.req_check ? ST_CHECK : ST_RD_SRC;
            end
         end
         ST_RD_SRC: begin
            cmd.road_read = 1'b1;
            state_in      = ST_WR_SRC;
         end
         ST_WR_SRC: begin
            cmd.road_write = 1'b1;
            state_in       = status.two_way ? ST_RD_DST : ST_IDLE;
         end
         ST_RD_DST: begin
            cmd.road_read = 1'b1;
            cmd.road_rev  = 1'b1;
            state_in      = ST_WR_DST;
         end
         ST_WR_DST: begin
            cmd.road_write = 1'b1;
            cmd.road_rev   = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_CHECK: begin
            state_in = status.trivial ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.last_row) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last row of the sweep lands now; sweep again while sets grow
            if (status.changed) begin
               cmd.sweep_restart = 1'b1;
               state_in          = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/scc_datapath.sv
module scc_datapath #(
   parameter int MAX_NODES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   scc_req_if.sink                 req_ch,
   scc_rsp_if.source               rsp_ch,
   input  scc_pkg::scc_cmd_type    cmd,
   output scc_pkg::scc_status_type status
);
   import scc_pkg::*;

   localparam int IdxW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int CmpW = ((IdxW > COUNT_W) ? IdxW : COUNT_W) + 1;

   // adjacency store, one row per source node, with a valid bit per row
   logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff;

   logic [NODE_W-1:0]    src_ff;
   logic [NODE_W-1:0]    dst_ff;
   logic                 two_way_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [MAX_NODES-1:0] mask_ff;
   logic [MAX_NODES-1:0] mask_in;
   logic [MAX_NODES-1:0] fwd_ff;
   logic [MAX_NODES-1:0] fwd_in;
   logic [MAX_NODES-1:0] bwd_ff;
   logic [MAX_NODES-1:0] bwd_in;
   logic [IdxW-1:0]      ctr_ff;
   logic                 changed_ff;

   logic [MAX_NODES-1:0] rd_data_ff;
   logic                 rd_ok_ff;
   logic [IdxW-1:0]      rd_row_ff;
   logic                 rd_pend_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_conn_ff;

   logic                 take_xfer;
   logic [IdxW-1:0]      src_idx;
   logic [IdxW-1:0]      dst_idx;
   logic                 drop;
   logic                 rd_en;
   logic [IdxW-1:0]      rd_addr;
   logic [MAX_NODES-1:0] rd_row;
   logic                 wr_en;
   logic [IdxW-1:0]      wr_addr;
   logic [MAX_NODES-1:0] wr_data;
   logic                 bwd_hit;
   logic                 grow;
   logic                 small_count;
   logic                 too_large;
   logic                 answer;

   function automatic logic [MAX_NODES-1:0] row_bit(input logic [IdxW-1:0] n);
      logic [MAX_NODES-1:0] b;
      for (int i = 0; i < MAX_NODES; i++) begin
         b[i] = (n == IdxW'(i));
      end
      return b;
   endfunction

   assign req_ch.ready = cmd.take;
   assign take_xfer    = cmd.take & req_ch.valid;

   // node range mask from the offered count
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         mask_in[i] = CmpW'(i) < CmpW'(req_ch.node_count);
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (take_xfer) begin
         src_ff     <= req_ch.source_node;
         dst_ff     <= req_ch.dest_node;
         two_way_ff <= req_ch.two_way;
         count_ff   <= req_ch.node_count;
         mask_ff    <= mask_in;
      end
   end

   // road addressing; edges touching a node beyond the store are dropped
   assign src_idx = IdxW'(src_ff);
   assign dst_idx = IdxW'(dst_ff);
   assign drop    = (CmpW'(src_ff) >= CmpW'(MAX_NODES)) |
                    (CmpW'(dst_ff) >= CmpW'(MAX_NODES));

   // single read port shared by road edits and sweeps
   assign rd_en   = cmd.scan_read | cmd.road_read;
   assign rd_addr = cmd.scan_read ? ctr_ff : (cmd.road_rev ? dst_idx : src_idx);
   assign rd_row  = rd_ok_ff ? rd_data_ff : '0;

   // read-modify-write of a road row
   assign wr_en   = cmd.road_write & ~drop;
   assign wr_addr = cmd.road_rev ? dst_idx : src_idx;
   assign wr_data = rd_row | row_bit(cmd.road_rev ? src_idx : dst_idx);

   // adjacency memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
         rd_ok_ff   <= row_valid_ff[rd_addr];
         rd_row_ff  <= rd_addr;
      end
   end

   // row valid bits, cleared at reset and after every check
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // closure update for the row that has just been read
   always_comb begin
      fwd_in  = fwd_ff;
      bwd_in  = bwd_ff;
      bwd_hit = 1'b0;
      if (rd_pend_ff) begin
         if (fwd_ff[rd_row_ff]) begin
            fwd_in = fwd_ff | (rd_row & mask_ff);
         end
         bwd_hit = ~bwd_ff[rd_row_ff] & (|(rd_row & bwd_ff));
         if (bwd_hit) begin
            bwd_in = bwd_ff | row_bit(rd_row_ff);
         end
      end
      grow = rd_pend_ff & ((fwd_in != fwd_ff) | bwd_hit);
   end

   // forward and backward reached sets, seeded with node zero
   always_ff @(posedge clock) begin
      if (take_xfer) begin
         fwd_ff <= row_bit('0);
         bwd_ff <= row_bit('0);
      end else begin
         fwd_ff <= fwd_in;
         bwd_ff <= bwd_in;
      end
   end

   // sweep row counter and growth flag
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff     <= '0;
         changed_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_read;
         if (take_xfer || cmd.sweep_restart) begin
            ctr_ff     <= '0;
            changed_ff <= 1'b0;
         end else begin
            if (cmd.scan_read) begin
               ctr_ff <= ctr_ff + IdxW'(1);
            end
            changed_ff <= changed_ff | grow;
         end
      end
   end

   // answer
   assign small_count = CmpW'(count_ff) <= CmpW'(1);
   assign too_large   = CmpW'(count_ff) > CmpW'(MAX_NODES);
   assign answer      = small_count |
                        (~too_large & (fwd_ff == mask_ff) & (bwd_ff == mask_ff));

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_conn_ff <= answer;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.connected = rsp_conn_ff;

   // status to the controller
   always_comb begin
      status           = '0;
      status.req_valid = req_ch.valid;
      status.req_check = (req_ch.func == FUNC_CHECK);
      status.two_way   = two_way_ff;
      status.trivial   = small_count | too_large;
      status.last_row  = CmpW'(ctr_ff) == (CmpW'(count_ff) - CmpW'(1));
      status.changed   = changed_ff | grow;
      status.out_free  = ~rsp_valid_ff | rsp_ch.ready;
   end

endmodule

// File: rtl/strong_connectivity_check_top.sv
// Strong connectivity check. Roads (func add) are written into an adjacency
// store of MAX_NODES rows, one bit per destination; a one-way road passes a
// read and a write state and a two-way road two of each, because each edge
// is a read-modify-write of one row through the single memory port. A check
// item returns one answer: 1 when every node below node_count reaches every
// other, 0 otherwise; a count of 0 or 1 answers 1 and a count above MAX_NODES
// answers 0 without a sweep. Otherwise the datapath sweeps the rows
// 0..node_count-1, one row per cycle, growing the set reached from node zero
// and the set that reaches node zero together, and repeats the sweep until
// neither set grows: with n nodes a check takes at most 2n - 1 sweeps. After
// every check the graph is empty again; the row valid bits are cleared as the
// answer is published. A finished answer waits in an output register, and
// roads are taken meanwhile.
module strong_connectivity_check_top #(
   parameter int MAX_NODES = 64
) (
   input logic       clock,
   input logic       reset,
   scc_req_if.sink   req_ch,
   scc_rsp_if.source rsp_ch
);
   import scc_pkg::*;

   scc_cmd_type    cmd;
   scc_status_type status;

   // sequencing of road edits and sweeps
   scc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // adjacency store, reached sets and response register
   scc_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// File: test/strong_connectivity_check_top_test.sv
module strong_connectivity_check_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import scc_pkg::*;

   localparam int NODES        = 64;
   localparam int RANDOM_ITEMS = 1850;
   localparam int MIN_CHECKS   = 48;

   // expected answers of the graph checks, kept in transfer order
   class connectivity_scoreboard;
      logic [NODES-1:0] adj_rows [NODES];
      bit               pending_answers [$];
      int               failures;

      function new();
         failures = 0;
         clear_graph();
      endfunction

      function void clear_graph();
         foreach (adj_rows[i]) adj_rows[i] = '0;
      endfunction

      // forward closure from node zero and backward closure to it
      function bit strongly_connected(logic [COUNT_W-1:0] cnt);
         logic [NODES-1:0] mask;
         logic [NODES-1:0] fwd;
         logic [NODES-1:0] frontier;
         logic [NODES-1:0] next_set;
         logic [NODES-1:0] bwd;
         bit               grew;
         if (cnt <= 1) return 1'b1;
         if (cnt > NODES) return 1'b0;
         mask = (cnt == NODES) ? '1 : ((64'd1 << cnt) - 64'd1);
         fwd = 64'd1;
         frontier = 64'd1;
         grew = 1'b1;
         while (grew) begin
            next_set = '0;
            for (int v = 0; v < cnt; v++) begin
               if (frontier[v]) next_set |= adj_rows[v] & mask;
            end
            frontier = next_set & ~fwd;
            fwd |= frontier;
            grew = (frontier != '0);
         end
         bwd = 64'd1;
         grew = 1'b1;
         while (grew) begin
            grew = 1'b0;
            for (int v = 0; v < cnt; v++) begin
               if (!bwd[v] && ((adj_rows[v] & bwd) != '0)) begin
                  bwd[v] = 1'b1;
                  grew = 1'b1;
               end
            end
         end
         return (fwd == mask) && (bwd == mask);
      endfunction

      function void note_request(logic [FUNC_W-1:0] f, logic [NODE_W-1:0] s,
                                 logic [NODE_W-1:0] d, logic tw,
                                 logic [COUNT_W-1:0] cnt);
         if (f == FUNC_ADD_ROAD) begin
            adj_rows[s][d] = 1'b1;
            if (tw) adj_rows[d][s] = 1'b1;
         end else begin
            pending_answers.insert(pending_answers.size(), strongly_connected(cnt));
            clear_graph();
         end
      endfunction

      function void check_answer(logic connected);
         bit want;
         if (pending_answers.size() == 0) begin
            $display("%0t: response with nothing expected, actual connected=%b",
                     $time, connected);
            failures++;
            return;
         end
         want = pending_answers.pop_front();
         if (connected !== want) begin
            $display("%0t: connected mismatch, expected %b actual %b",
                     $time, want, connected);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   scc_req_if req_ch ();
   scc_rsp_if rsp_ch ();

   connectivity_scoreboard board;
   int items_sent;
   int checks_sent;
   bit sender_calm;

   strong_connectivity_check_top #(
      .MAX_NODES(NODES)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // known values from the start
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_ADD_ROAD;
      req_ch.source_node = '0;
      req_ch.dest_node = '0;
      req_ch.two_way = 1'b0;
      req_ch.node_count = '0;
      rsp_ch.ready = 1'b0;
   end

   // one request transfer, after a random gap unless the sender is calm
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [NODE_W-1:0] s,
                            input logic [NODE_W-1:0] d, input logic tw,
                            input logic [COUNT_W-1:0] cnt);
      int gap;
      bit took;
      gap = sender_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.source_node <= s;
      req_ch.dest_node <= d;
      req_ch.two_way <= tw;
      req_ch.node_count <= cnt;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end
      board.note_request(f, s, d, tw, cnt);
      items_sent++;
   endtask

   // unused payload fields carry random bits
   task automatic send_road(input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d,
                            input logic tw);
      send_item(FUNC_ADD_ROAD, s, d, tw, COUNT_W'($urandom_range(0, 127)));
   endtask

   task automatic send_check(input logic [COUNT_W-1:0] cnt);
      send_item(FUNC_CHECK, NODE_W'($urandom_range(0, 63)), NODE_W'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), cnt);
      checks_sent++;
   endtask

   // a graph over nodes 0..k-1 of a chosen shape, then a check
   task automatic send_graph_group();
      int k;
      int shape;
      int missing;
      int cnt;
      int j;
      int tmp;
      int b;
      int order [NODES];
      if ($urandom_range(0, 39) == 0) k = $urandom_range(32, 64);
      else k = $urandom_range(2, 10);
      for (int i = 0; i < NODES; i++) order[i] = i;
      for (int i = k - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      shape = $urandom_range(0, 3);
      missing = $urandom_range(0, k - 1);
      case (shape)
         0: begin
            // directed ring
            for (int i = 0; i < k; i++)
               send_road(NODE_W'(order[i]), NODE_W'(order[(i + 1) % k]), 1'b0);
         end
         1: begin
            // two-way chain
            for (int i = 0; i < k - 1; i++)
               send_road(NODE_W'(order[i]), NODE_W'(order[i + 1]), 1'b1);
         end
         2: begin
            // ring with one road left out
            for (int i = 0; i < k; i++) begin
               if (i != missing)
                  send_road(NODE_W'(order[i]), NODE_W'(order[(i + 1) % k]),
                            1'($urandom_range(0, 1)));
            end
         end
         default: begin
            repeat ($urandom_range(k, 2 * k))
               send_road(NODE_W'($urandom_range(0, k - 1)),
                         NODE_W'($urandom_range(0, k - 1)),
                         1'($urandom_range(0, 1)));
         end
      endcase
      // a few extra roads, some leaving the graph
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 63);
         else b = $urandom_range(0, k - 1);
         send_road(NODE_W'($urandom_range(0, k - 1)), NODE_W'(b),
                   1'($urandom_range(0, 1)));
      end
      cnt = k;
      case ($urandom_range(0, 7))
         0: cnt = k - 1;
         1: cnt = k + 1;
         default: ;
      endcase
      send_check(COUNT_W'(cnt));
   endtask

   // random roads anywhere and a check of any count
   task automatic send_noise_group();
      int cnt;
      repeat ($urandom_range(0, 6))
         send_road(NODE_W'($urandom_range(0, 63)), NODE_W'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) cnt = $urandom_range(0, 127);
      else cnt = $urandom_range(0, 12);
      send_check(COUNT_W'(cnt));
   endtask

   // response side with random stalls
   initial begin
      logic answer;
      bit   seen;
      int   gap;
      int   answers_taken;
      bit   calm;
      answers_taken = 0;
      calm = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (answers_taken % 16 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         seen = 1'b0;
         while (!seen) begin
            @(negedge clock);
            seen = rsp_ch.valid;
            answer = rsp_ch.connected;
            @(posedge clock);
         end
         board.check_answer(answer);
         answers_taken++;
      end
   end

   // stimulus
   initial begin
      board = new();
      items_sent = 0;
      checks_sent = 0;
      sender_calm = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // small graphs answer true, even when empty
      send_check(7'd0);
      send_check(7'd1);
      // empty pair is not connected
      send_check(7'd2);
      send_road(6'd0, 6'd1, 1'b1);
      send_check(7'd2);
      // extreme node numbers, the middle nodes stay unreached
      send_road(6'd63, 6'd0, 1'b0);
      send_road(6'd0, 6'd63, 1'b0);
      send_check(7'd64);
      // count above the store answers false
      send_road(6'd0, 6'd1, 1'b1);
      send_check(7'd65);
      send_check(7'd127);
      // roads out of the counted nodes are ignored
      send_road(6'd0, 6'd5, 1'b1);
      send_road(6'd1, 6'd0, 1'b1);
      send_check(7'd2);
      // self loop only
      send_road(6'd3, 6'd3, 1'b0);
      send_check(7'd2);
      // graph is emptied after every check
      send_road(6'd1, 6'd0, 1'b1);
      send_check(7'd2);
      send_check(7'd2);
      // one-way ring and one-way chain
      send_road(6'd0, 6'd1, 1'b0);
      send_road(6'd1, 6'd2, 1'b0);
      send_road(6'd2, 6'd0, 1'b0);
      send_check(7'd3);
      send_road(6'd0, 6'd1, 1'b0);
      send_road(6'd1, 6'd2, 1'b0);
      send_check(7'd3);

      // hold off until every answer is back
      req_ch.valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(posedge clock);
      @(posedge clock);

      items_sent = 0;
      checks_sent = 0;
      while (items_sent < RANDOM_ITEMS || checks_sent < MIN_CHECKS) begin
         sender_calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 3) == 0) send_noise_group();
         else send_graph_group();
      end

      // drain
      req_ch.valid <= 1'b0;
      while (board.pending_answers.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (board.failures == 0) begin
         $display("[strong_connectivity_check_top] OK");
      end else begin
         $display("[strong_connectivity_check_top] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("[strong_connectivity_check_top] ERROR");
      $finish;
   end

endmodule
